// ----- rtl/core/pes_pkg.sv -----
package pes_pkg;

	// default sizes
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_PRIOS_DEF   = 8;
	localparam int TICK_RATES_DEF  = 2;

	// priority index carried in a command (up to eight priorities)
	localparam int QI_W = 3;

	localparam logic [7:0] MUST_POST      = 8'hFF;
	localparam logic [3:0] NUM_ACTIVE_RST = 4'd8;
	localparam logic [7:0] TO_BASE_RST    = 8'd4;

	// configuration register indexes
	localparam logic CFG_NUM_ACTIVE = 1'b0;
	localparam logic CFG_TO_BASE    = 1'b1;

	// input kind codes
	localparam logic [2:0] KIND_POST     = 3'd0;
	localparam logic [2:0] KIND_DISPATCH = 3'd1;
	localparam logic [2:0] KIND_TICK     = 3'd2;
	localparam logic [2:0] KIND_ARM      = 3'd3;
	localparam logic [2:0] KIND_DISARM   = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_POST,
		OP_DISPATCH,
		OP_TICK,
		OP_ARM,
		OP_DISARM
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [3:0] num_active;
		logic [7:0] to_base;
	} cfg_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t             op;
		logic [QI_W-1:0] qi;
		logic [3:0]      n;
		logic [7:0]      margin;
		logic [7:0]      sig;
		logic [31:0]     param;
		logic            rate;
		logic            rate_ok;
		logic [15:0]     ticks;
		logic [15:0]     reload;
	} cmd_t;

endpackage

// ----- rtl/core/pes_if.sv -----
interface pes_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  target_prio;
	logic [7:0]  margin;
	logic [7:0]  signal;
	logic [31:0] param;
	logic        tick_rate;
	logic [15:0] tick_count;
	logic [15:0] reload_interval;

	modport source (output valid, kind, target_prio, margin, signal, param, tick_rate,
		tick_count, reload_interval, input ready);
	modport sink (input valid, kind, target_prio, margin, signal, param, tick_rate,
		tick_count, reload_interval, output ready);
endinterface

interface pes_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        error;
	logic        event_valid;
	logic [3:0]  event_prio;
	logic [7:0]  event_signal;
	logic [31:0] event_param;
	logic [7:0]  ready_set;
	logic [7:0]  timers_running;

	modport source (output valid, accepted, error, event_valid, event_prio, event_signal,
		event_param, ready_set, timers_running, input ready);
	modport sink (input valid, accepted, error, event_valid, event_prio, event_signal,
		event_param, ready_set, timers_running, output ready);
endinterface

// ----- rtl/core/priority_event_scheduler_with_timers_core.sv -----
// Flow: an item first waits in the two-entry command queue; the sequencer then pops
// it in IDLE and moves to DONE for post, dispatch, arm, disarm and ignored items,
// while a tick passes through TICK before DONE, visiting one priority's timer per cycle.
// The sequencer pops no new item until the single result register has drained,
// so items are handled one at a time.
// Reset: asynchronous, clears queues, timers, ready and running sets at once.
module priority_event_scheduler_with_timers_core
	import pes_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int MAX_PRIOS   = MAX_PRIOS_DEF,
	parameter int TICK_RATES  = TICK_RATES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pes_req_if.sink    req,
	pes_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	pes_front #(.MAX_PRIOS(MAX_PRIOS), .TICK_RATES(TICK_RATES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	pes_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_PRIOS   (MAX_PRIOS),
		.TICK_RATES  (TICK_RATES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/pes_ram.sv -----
module pes_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/pes_front.sv -----
module pes_front
	import pes_pkg::*;
#(
	parameter int MAX_PRIOS  = MAX_PRIOS_DEF,
	parameter int TICK_RATES = TICK_RATES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pes_req_if.sink    req,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	cfg_t       cfg_q;
	cmd_t       fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic [3:0] n;
	logic       prio_ok, rate_ok, push;
	cmd_t       c;

	assign cfg = cfg_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_active <= NUM_ACTIVE_RST;
			cfg_q.to_base    <= TO_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_ACTIVE: cfg_q.num_active <= cfg_data[3:0];
				CFG_TO_BASE:    cfg_q.to_base    <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify incoming item
	always_comb begin
		if (cfg_q.num_active == 4'd0) n = 4'd1;
		else if (cfg_q.num_active > 4'(MAX_PRIOS)) n = 4'(MAX_PRIOS);
		else n = cfg_q.num_active;
		prio_ok = (req.target_prio != 4'd0) && (req.target_prio <= n);
		rate_ok = {31'd0, req.tick_rate} < TICK_RATES;
		c.qi      = QI_W'(req.target_prio - 4'd1);
		c.n       = n;
		c.margin  = req.margin;
		c.sig     = req.signal;
		c.param   = req.param;
		c.rate    = req.tick_rate;
		c.rate_ok = rate_ok;
		c.ticks   = req.tick_count;
		c.reload  = req.reload_interval;
		case (req.kind)
			KIND_POST:     c.op = prio_ok ? OP_POST : OP_NOP;
			KIND_DISPATCH: c.op = OP_DISPATCH;
			KIND_TICK:     c.op = rate_ok ? OP_TICK : OP_NOP;
			KIND_ARM:      c.op = (prio_ok && rate_ok) ? OP_ARM : OP_NOP;
			KIND_DISARM:   c.op = (prio_ok && rate_ok) ? OP_DISARM : OP_NOP;
			default:       c.op = OP_NOP;
		endcase
	end

	// two-entry command queue
	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

// ----- rtl/core/pes_back.sv -----
module pes_back
	import pes_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int MAX_PRIOS   = MAX_PRIOS_DEF,
	parameter int TICK_RATES  = TICK_RATES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     cmd_valid,
	input  cmd_t     cmd,
	output logic     cmd_pop,
	pes_rsp_if.source rsp
);

	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int QIW = $clog2(MAX_PRIOS);
	localparam int RIW = (TICK_RATES > 1) ? $clog2(TICK_RATES) : 1;
	localparam int AW  = $clog2(MAX_PRIOS * QUEUE_DEPTH);

	state_t st_q, st_d;

	logic [PW-1:0]        wp_q   [MAX_PRIOS];
	logic [PW-1:0]        rp_q   [MAX_PRIOS];
	logic [FW-1:0]        fill_q [MAX_PRIOS];
	logic [MAX_PRIOS-1:0] ready_q;
	logic [15:0]          rem_q  [MAX_PRIOS][TICK_RATES];
	logic [15:0]          rld_q  [MAX_PRIOS][TICK_RATES];
	logic [MAX_PRIOS-1:0] run_q  [TICK_RATES];

	logic [3:0]   p_q;
	logic         cur_rate_ok_q;
	logic [RIW-1:0] cur_ri_q;
	logic         acc_q, err_q, hit_q;
	logic [3:0]   hit_prio_q;
	logic         out_valid_q;

	// shared enqueue and dispatch controls
	logic           enq_req, enq_must, enq_ok, enq_err;
	logic [QIW-1:0] enq_qi, dsp_qi, tq, cq;
	logic [7:0]     enq_margin, enq_sig;
	logic [31:0]    enq_par;
	logic [FW-1:0]  enq_fill;
	logic           dsp_req, tick_hit, tick_expire;
	logic [15:0]    tick_rem;
	logic [RIW-1:0] cri;
	logic [AW-1:0]  waddr, raddr;
	logic [39:0]    rdata;

	assign cq  = cmd.qi[QIW-1:0];
	assign cri = RIW'(cmd.rate);
	assign tq  = QIW'(p_q - 4'd1);
	assign tick_rem    = rem_q[tq][cur_ri_q];
	assign tick_hit    = (tick_rem != 16'd0);
	assign tick_expire = (tick_rem == 16'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// sequencer: next state and per-cycle actions
	always_comb begin
		st_d       = st_q;
		cmd_pop    = 1'b0;
		enq_req    = 1'b0;
		enq_must   = 1'b0;
		enq_qi     = cq;
		enq_margin = cmd.margin;
		enq_sig    = cmd.sig;
		enq_par    = cmd.param;
		dsp_req    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_POST: begin
							enq_req  = 1'b1;
							enq_must = (cmd.margin == MUST_POST);
							st_d     = ST_DONE;
						end
						OP_DISPATCH: begin
							dsp_req = |ready_q;
							st_d    = ST_DONE;
						end
						OP_TICK: st_d = ST_TICK;
						default: st_d = ST_DONE;
					endcase
				end
			end
			ST_TICK: begin
				enq_req    = tick_hit && tick_expire;
				enq_must   = 1'b1;
				enq_qi     = tq;
				enq_sig    = 8'(cfg.to_base + 8'(cur_ri_q));
				enq_par    = 32'd0;
				st_d       = (p_q == 4'd1) ? ST_DONE : ST_TICK;
			end
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// highest ready priority
	always_comb begin
		dsp_qi = '0;
		for (int i = 0; i < MAX_PRIOS; i++) begin
			if (ready_q[i]) dsp_qi = QIW'(i);
		end
	end

	// margin check
	always_comb begin
		enq_fill = fill_q[enq_qi];
		if (enq_must) begin
			enq_ok  = {1'b0, enq_fill} < (FW + 1)'(QUEUE_DEPTH);
			enq_err = !enq_ok;
		end else begin
			enq_ok  = (10'(QUEUE_DEPTH) - 10'(enq_fill)) > 10'(enq_margin);
			enq_err = 1'b0;
		end
	end

	assign waddr = AW'(enq_qi) * AW'(QUEUE_DEPTH) + AW'(wp_q[enq_qi]);
	assign raddr = AW'(dsp_qi) * AW'(QUEUE_DEPTH) + AW'(rp_q[dsp_qi]);

	pes_ram #(.WIDTH(40), .DEPTH(MAX_PRIOS * QUEUE_DEPTH)) u_store (
		.clk   (clk),
		.we    (enq_req && enq_ok),
		.waddr (waddr),
		.wdata ({enq_sig, enq_par}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// queue, timer and result state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PRIOS; i++) begin
				wp_q[i]   <= '0;
				rp_q[i]   <= '0;
				fill_q[i] <= '0;
				for (int r = 0; r < TICK_RATES; r++) begin
					rem_q[i][r] <= 16'd0;
					rld_q[i][r] <= 16'd0;
				end
			end
			for (int r = 0; r < TICK_RATES; r++) run_q[r] <= '0;
			ready_q       <= '0;
			p_q           <= 4'd0;
			cur_rate_ok_q <= 1'b0;
			cur_ri_q      <= '0;
			acc_q         <= 1'b0;
			err_q         <= 1'b0;
			hit_q         <= 1'b0;
			hit_prio_q    <= 4'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (enq_req && enq_ok) begin
				wp_q[enq_qi]    <= (wp_q[enq_qi] == PW'(QUEUE_DEPTH - 1)) ? '0
					: wp_q[enq_qi] + PW'(1);
				fill_q[enq_qi]  <= enq_fill + FW'(1);
				ready_q[enq_qi] <= 1'b1;
			end
			if (dsp_req) begin
				rp_q[dsp_qi]   <= (rp_q[dsp_qi] == PW'(QUEUE_DEPTH - 1)) ? '0
					: rp_q[dsp_qi] + PW'(1);
				fill_q[dsp_qi] <= fill_q[dsp_qi] - FW'(1);
				if (fill_q[dsp_qi] == FW'(1)) ready_q[dsp_qi] <= 1'b0;
			end
			if (cmd_pop) begin
				cur_rate_ok_q <= cmd.rate_ok;
				cur_ri_q      <= cri;
				acc_q         <= (cmd.op == OP_POST) && enq_ok;
				err_q         <= (cmd.op == OP_POST) && enq_err;
				hit_q         <= dsp_req;
				hit_prio_q    <= 4'(dsp_qi) + 4'd1;
				p_q           <= cmd.n;
				case (cmd.op)
					OP_ARM: begin
						rem_q[cq][cri] <= cmd.ticks;
						rld_q[cq][cri] <= cmd.reload;
						run_q[cri][cq] <= 1'b1;
					end
					OP_DISARM: begin
						rem_q[cq][cri] <= 16'd0;
						rld_q[cq][cri] <= 16'd0;
						run_q[cri][cq] <= 1'b0;
					end
					default: ;
				endcase
			end
			// one timer per cycle, highest priority first
			if (st_q == ST_TICK) begin
				p_q <= p_q - 4'd1;
				if (tick_hit) begin
					if (tick_expire) begin
						rem_q[tq][cur_ri_q] <= rld_q[tq][cur_ri_q];
						run_q[cur_ri_q][tq] <= 1'b0;
						if (enq_err) err_q <= 1'b1;
					end else begin
						rem_q[tq][cur_ri_q] <= tick_rem - 16'd1;
					end
				end
			end
			if (st_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (st_q == ST_DONE) begin
			rsp.accepted       <= acc_q;
			rsp.error          <= err_q;
			rsp.event_valid    <= hit_q;
			rsp.event_prio     <= hit_q ? hit_prio_q : 4'd0;
			rsp.event_signal   <= hit_q ? rdata[39:32] : 8'd0;
			rsp.event_param    <= hit_q ? rdata[31:0] : 32'd0;
			rsp.ready_set      <= 8'(ready_q);
			rsp.timers_running <= cur_rate_ok_q ? 8'(run_q[cur_ri_q]) : 8'd0;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

// ----- rtl/core/pes_checker.sv -----
module pes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        accepted,
	input logic        error,
	input logic        event_valid,
	input logic [3:0]  event_prio,
	input logic [7:0]  event_signal,
	input logic [31:0] event_param
);

	// stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(event_param) && $stable(event_prio))
		else $error("result changed while stalled");

	// a dispatched event always names a priority
	a_prio: assert property (@(posedge clk) disable iff (!arst_n)
		valid && event_valid |-> event_prio != 4'd0)
		else $error("event without priority");

	// empty event fields are zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !event_valid |-> event_prio == 4'd0 && event_signal == 8'd0
			&& event_param == 32'd0)
		else $error("empty event not cleared");

	// a post result is never also an error or an event
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		valid && accepted |-> !error && !event_valid)
		else $error("accepted with error or event");

endmodule

bind priority_event_scheduler_with_timers_core pes_checker u_pes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (rsp.valid),
	.ready        (rsp.ready),
	.accepted     (rsp.accepted),
	.error        (rsp.error),
	.event_valid  (rsp.event_valid),
	.event_prio   (rsp.event_prio),
	.event_signal (rsp.event_signal),
	.event_param  (rsp.event_param)
);

// ----- dv/tb_top.sv -----
module tb_top;
	import pes_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH    = 16;
	localparam int PRIOS    = 8;
	localparam int RATES    = 2;
	localparam int IDLE_LIM = 5000;
	localparam int SETTLE   = 24;

	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  prio;
		logic [7:0]  margin;
		logic [7:0]  sig;
		logic [31:0] param;
		logic        rate;
		logic [15:0] ticks;
		logic [15:0] reload;
	} cmd_item_t;

	typedef struct {
		logic        accepted;
		logic        error;
		logic        ev_valid;
		logic [3:0]  ev_prio;
		logic [7:0]  ev_sig;
		logic [31:0] ev_param;
		logic [7:0]  ready_set;
		logic [7:0]  running;
	} sched_rsp_t;

	typedef struct {
		cmd_item_t  item;
		int         reps;
		bit         fixed;
		sched_rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	pes_req_if req_ch();
	pes_rsp_if rsp_ch();

	priority_event_scheduler_with_timers_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scheduler shadow state
	logic [3:0]  sh_num_active;
	logic [7:0]  sh_to_base;
	logic [7:0]  q_sig   [PRIOS][DEPTH];
	logic [31:0] q_param [PRIOS][DEPTH];
	int          q_wr    [PRIOS];
	int          q_rd    [PRIOS];
	int          q_fill  [PRIOS];
	logic [7:0]  ready_bits;
	logic [15:0] t_left  [PRIOS][RATES];
	logic [15:0] t_reload[PRIOS][RATES];
	logic [7:0]  run_bits[RATES];

	sched_rsp_t pending_rsp[$];
	int fail_count = 0;
	int idle_cycles = 0;
	stim_row_t rows[$];

	function automatic int prios_in_use();
		int n;
		n = sh_num_active;
		if (n == 0) n = 1;
		if (n > PRIOS) n = PRIOS;
		return n;
	endfunction

	// returns 1 enqueued, 0 refused, 2 must-post overflow
	function automatic int enqueue_event(int p, logic [7:0] m, logic [7:0] s, logic [31:0] v);
		int q;
		bit ok;
		q = p - 1;
		if (m == MUST_POST) begin
			ok = q_fill[q] < DEPTH;
			if (!ok) return 2;
		end else begin
			ok = (DEPTH - q_fill[q]) > m;
			if (!ok) return 0;
		end
		q_sig[q][q_wr[q]] = s;
		q_param[q][q_wr[q]] = v;
		q_wr[q] = (q_wr[q] + 1) % DEPTH;
		q_fill[q]++;
		ready_bits[q] = 1'b1;
		return 1;
	endfunction

	function automatic sched_rsp_t schedule_step(cmd_item_t it);
		sched_rsp_t r;
		int n, p, q, st;
		bit prio_ok;
		r = '{default: '0};
		n = prios_in_use();
		prio_ok = it.prio >= 1 && it.prio <= n;
		case (it.kind)
			KIND_POST: begin
				if (prio_ok) begin
					st = enqueue_event(it.prio, it.margin, it.sig, it.param);
					r.accepted = st == 1;
					r.error = st == 2;
				end
			end
			KIND_DISPATCH: begin
				for (p = PRIOS; p >= 1; p--) begin
					q = p - 1;
					if (ready_bits[q]) begin
						r.ev_valid = 1'b1;
						r.ev_prio = 4'(p);
						r.ev_sig = q_sig[q][q_rd[q]];
						r.ev_param = q_param[q][q_rd[q]];
						q_rd[q] = (q_rd[q] + 1) % DEPTH;
						if (q_fill[q] > 0) q_fill[q]--;
						if (q_fill[q] == 0) ready_bits[q] = 1'b0;
						break;
					end
				end
			end
			KIND_TICK: begin
				for (p = n; p >= 1; p--) begin
					q = p - 1;
					if (t_left[q][it.rate] != 0) begin
						t_left[q][it.rate]--;
						if (t_left[q][it.rate] == 0) begin
							t_left[q][it.rate] = t_reload[q][it.rate];
							run_bits[it.rate][q] = 1'b0;
							if (enqueue_event(p, MUST_POST, 8'(sh_to_base + 8'(it.rate)),
									'0) == 2)
								r.error = 1'b1;
						end
					end
				end
			end
			KIND_ARM: begin
				if (prio_ok) begin
					t_left[it.prio-1][it.rate] = it.ticks;
					t_reload[it.prio-1][it.rate] = it.reload;
					run_bits[it.rate][it.prio-1] = 1'b1;
				end
			end
			KIND_DISARM: begin
				if (prio_ok) begin
					t_left[it.prio-1][it.rate] = '0;
					t_reload[it.prio-1][it.rate] = '0;
					run_bits[it.rate][it.prio-1] = 1'b0;
				end
			end
			default: ;
		endcase
		r.ready_set = ready_bits;
		r.running = run_bits[it.rate];
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	// result check and receiver stall pattern
	int stall_mode = 0;
	int mode_left = 0;
	always @(posedge clk) begin
		sched_rsp_t w;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				w = pending_rsp.pop_front();
				if (rsp_ch.accepted !== w.accepted) report("accepted", rsp_ch.accepted, w.accepted);
				if (rsp_ch.error !== w.error) report("error", rsp_ch.error, w.error);
				if (rsp_ch.event_valid !== w.ev_valid)
					report("event_valid", rsp_ch.event_valid, w.ev_valid);
				if (rsp_ch.event_prio !== w.ev_prio)
					report("event_prio", rsp_ch.event_prio, w.ev_prio);
				if (rsp_ch.event_signal !== w.ev_sig)
					report("event_signal", rsp_ch.event_signal, w.ev_sig);
				if (rsp_ch.event_param !== w.ev_param)
					report("event_param", rsp_ch.event_param, w.ev_param);
				if (rsp_ch.ready_set !== w.ready_set)
					report("ready_set", rsp_ch.ready_set, w.ready_set);
				if (rsp_ch.timers_running !== w.running)
					report("timers_running", rsp_ch.timers_running, w.running);
			end
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(8, 80);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
			default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	int burst_left = 0;

	task automatic send_item(cmd_item_t it, bit fixed, sched_rsp_t want);
		sched_rsp_t got;
		req_ch.valid <= 1'b1;
		req_ch.kind <= it.kind;
		req_ch.target_prio <= it.prio;
		req_ch.margin <= it.margin;
		req_ch.signal <= it.sig;
		req_ch.param <= it.param;
		req_ch.tick_rate <= it.rate;
		req_ch.tick_count <= it.ticks;
		req_ch.reload_interval <= it.reload;
		do @(posedge clk); while (!req_ch.ready);
		got = schedule_step(it);
		pending_rsp.push_back(fixed ? want : got);
		// bursts with random gaps between them
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 20) : 1;
			if ($urandom_range(0, 2) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic settle_then_cfg(logic idx, logic [7:0] val);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_ACTIVE) sh_num_active = val[3:0];
		else sh_to_base = val;
	endtask

	task automatic add_row(logic [2:0] k, logic [3:0] p, logic [7:0] m, logic [7:0] s,
			logic [31:0] v, logic r, logic [15:0] t, logic [15:0] rl, int reps = 1);
		stim_row_t row;
		row.item = '{k, p, m, s, v, r, t, rl};
		row.reps = reps;
		row.fixed = 1'b0;
		row.want = '{default: '0};
		rows.push_back(row);
	endtask

	// pin the expectation of the last row
	task automatic fix_last(logic acc, logic err, logic [7:0] rdy, logic [7:0] run);
		rows[rows.size()-1].fixed = 1'b1;
		rows[rows.size()-1].want = '{acc, err, 1'b0, 4'd0, 8'd0, 32'd0, rdy, run};
	endtask

	function automatic cmd_item_t random_item();
		cmd_item_t it;
		int sel, n;
		n = prios_in_use();
		sel = $urandom_range(0, 99);
		if (sel < 40) it.kind = KIND_POST;
		else if (sel < 70) it.kind = KIND_DISPATCH;
		else if (sel < 85) it.kind = KIND_TICK;
		else if (sel < 93) it.kind = KIND_ARM;
		else if (sel < 97) it.kind = KIND_DISARM;
		else it.kind = 3'($urandom_range(5, 7));
		it.prio = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, n))
			: 4'($urandom_range(0, 15));
		sel = $urandom_range(0, 9);
		it.margin = (sel < 4) ? MUST_POST
			: (sel < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
		it.sig = 8'($urandom);
		it.param = $urandom;
		it.rate = 1'($urandom_range(0, 1));
		it.ticks = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
		sel = $urandom_range(0, 9);
		it.reload = (sel < 5) ? 16'd0
			: (sel < 9) ? 16'($urandom_range(1, 4)) : 16'($urandom);
		return it;
	endfunction

	initial begin
		int i, ph;
		logic [3:0] act_set[5];
		sched_rsp_t none;
		none = '{default: '0};
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_POST;
		req_ch.target_prio = '0;
		req_ch.margin = '0;
		req_ch.signal = '0;
		req_ch.param = '0;
		req_ch.tick_rate = 1'b0;
		req_ch.tick_count = '0;
		req_ch.reload_interval = '0;
		rsp_ch.ready = 1'b0;
		sh_num_active = NUM_ACTIVE_RST;
		sh_to_base = TO_BASE_RST;
		ready_bits = '0;
		run_bits = '{default: '0};
		q_wr = '{default: 0};
		q_rd = '{default: 0};
		q_fill = '{default: 0};
		t_left = '{default: '0};
		t_reload = '{default: '0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: extremes, every kind, special cases
		add_row(KIND_DISPATCH, 4'd8, 8'd0, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0);
		fix_last(1'b0, 1'b0, 8'h00, 8'h00);
		add_row(KIND_POST, 4'd8, 8'd0, 8'hFF, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0);
		fix_last(1'b1, 1'b0, 8'h80, 8'h00);
		add_row(KIND_POST, 4'd0, MUST_POST, 8'h11, 32'h1, 1'b0, 16'd0, 16'd0);
		fix_last(1'b0, 1'b0, 8'h80, 8'h00);
		add_row(KIND_POST, 4'd15, MUST_POST, 8'h22, 32'h2, 1'b0, 16'd0, 16'd0);
		fix_last(1'b0, 1'b0, 8'h80, 8'h00);
		add_row(KIND_POST, 4'd1, 8'd15, 8'h00, 32'h0, 1'b0, 16'd0, 16'd0);
		fix_last(1'b1, 1'b0, 8'h81, 8'h00);
		// margin too large for the one free slot fewer: silently refused
		add_row(KIND_POST, 4'd1, 8'd15, 8'h33, 32'h3, 1'b0, 16'd0, 16'd0);
		fix_last(1'b0, 1'b0, 8'h81, 8'h00);
		// zero-tick arm runs but never expires
		add_row(KIND_ARM, 4'd2, 8'd0, 8'd0, 32'd0, 1'b1, 16'd0, 16'd0);
		fix_last(1'b0, 1'b0, 8'h81, 8'h02);
		add_row(KIND_ARM, 4'd3, 8'd0, 8'd0, 32'd0, 1'b0, 16'd1, 16'd2);
		add_row(KIND_TICK, 4'd0, 8'd0, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0, 3);
		add_row(KIND_DISARM, 4'd3, 8'd0, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0);
		add_row(3'd5, 4'd1, 8'd0, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0);
		add_row(3'd6, 4'd1, 8'd0, 8'd0, 32'd0, 1'b1, 16'd0, 16'd0);
		add_row(3'd7, 4'd1, 8'd0, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0);
		// fill queue 4, then must-post and timeout post overflow
		add_row(KIND_POST, 4'd4, MUST_POST, 8'h5A, 32'hA5A5_5A5A, 1'b0, 16'd0, 16'd0, 16);
		add_row(KIND_POST, 4'd4, MUST_POST, 8'h5B, 32'h0, 1'b0, 16'd0, 16'd0);
		add_row(KIND_ARM, 4'd4, 8'd0, 8'd0, 32'd0, 1'b1, 16'd1, 16'hFFFF);
		add_row(KIND_TICK, 4'd0, 8'd0, 8'd0, 32'd0, 1'b1, 16'd0, 16'd0);
		add_row(KIND_DISPATCH, 4'd0, 8'd0, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0, 22);
		add_row(KIND_ARM, 4'd8, 8'd0, 8'd0, 32'd0, 1'b0, 16'hFFFF, 16'hFFFF);
		add_row(KIND_DISARM, 4'd2, 8'd0, 8'd0, 32'd0, 1'b1, 16'd0, 16'd0);
		add_row(KIND_DISARM, 4'd4, 8'd0, 8'd0, 32'd0, 1'b1, 16'd0, 16'd0);

		foreach (rows[r])
			for (i = 0; i < rows[r].reps; i++)
				send_item(rows[r].item, rows[r].fixed, rows[r].want);

		// random phases over several register settings
		act_set = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1};
		for (ph = 0; ph < 5; ph++) begin
			req_ch.valid <= 1'b0;
			settle_then_cfg(CFG_NUM_ACTIVE, {4'd0, act_set[ph]});
			settle_then_cfg(CFG_TO_BASE, (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : 8'($urandom));
			for (i = 0; i < 100; i++) send_item(random_item(), 1'b0, none);
		end
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending_rsp.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
